// ----- hw/rtl/sorted_set_intersection_core_assert.svh -----
// Assertion helpers; sampled on clk_i, disabled while rst_ni is low.
`ifndef SORTED_SET_INTERSECTION_CORE_ASSERT_SVH
`define SORTED_SET_INTERSECTION_CORE_ASSERT_SVH

`define SSI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SSI_ASSERT_IMPL(name, ante, cons, msg) \
  `SSI_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/ssi_pkg.sv -----
package ssi_pkg;

  localparam int unsigned ListDepthDefault = 1024;
  localparam int unsigned ValueW           = 32;
  localparam int unsigned CountW           = 11;
  localparam int unsigned QueueDepth       = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdProbe = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ValueW-1:0] value;
    logic              last;
  } item_t;

endpackage

// ----- hw/rtl/ssi_if.sv -----
interface ssi_in_if import ssi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ValueW-1:0] value;
  logic              last;

  modport source (output valid, output operation, output value, output last, input ready);
  modport sink   (input valid, input operation, input value, input last, output ready);
endinterface

interface ssi_out_if import ssi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              matched;
  logic [ValueW-1:0] match_value;
  logic [CountW-1:0] match_count;
  logic              end_of_run;
  logic              overflow;

  modport source (output valid, output matched, output match_value, output match_count,
                  output end_of_run, output overflow, input ready);
  modport sink   (input valid, input matched, input match_value, input match_count,
                  input end_of_run, input overflow, output ready);
endinterface

// ----- hw/rtl/ssi_front.sv -----
module ssi_front import ssi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ssi_in_if.sink in_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned QIdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);
  localparam logic [QCntW-1:0] QFull = QCntW'(QueueDepth);
  localparam logic [QIdxW-1:0] QLast = QIdxW'(QueueDepth - 1);

  item_t            entry_q [QueueDepth];
  logic [QIdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  item_t            beat;

  always_comb begin
    beat.cmd   = in_i.operation ? CmdProbe : CmdLoad;
    beat.value = in_i.value;
    beat.last  = in_i.last;
  end

  assign in_i.ready  = (cnt_q != QFull);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_item_o  = entry_q[rd_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QLast) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QLast) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= beat;
    end
  end

endmodule

// ----- hw/rtl/ssi_back.sv -----
module ssi_back import ssi_pkg::*; #(
  parameter int unsigned ListDepth = ListDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  item_t      pop_item_i,
  ssi_out_if.source  out_o
);

  localparam int unsigned IdxW = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int unsigned LenW = $clog2(ListDepth + 1);
  localparam logic [LenW-1:0] DepthLen = LenW'(ListDepth);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic              state_q, state_d;
  logic [LenW-1:0]   len_q, len_d, ptr_q, ptr_d;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_next;
  logic              ovf_q, ovf_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              last_q, last_d;

  logic [ValueW-1:0] mem_q [ListDepth];
  logic [ValueW-1:0] rdata_q;
  logic              wr_en;

  logic              ov_q, ov_d;
  logic              om_q, om_d;
  logic [ValueW-1:0] oval_q, oval_d;
  logic [CountW-1:0] ocnt_q, ocnt_d;
  logic              oeor_q, oeor_d;
  logic              oovf_q, oovf_d;

  logic in_range, lower, hit, out_free;

  assign in_range    = (ptr_q < len_q);
  assign lower       = (rdata_q < val_q);
  assign hit         = in_range && (rdata_q == val_q);
  assign out_free    = !ov_q || out_o.ready;
  assign cnt_next    = (hit && (cnt_q != CountMax)) ? cnt_q + 1'b1 : cnt_q;
  assign pop_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    val_d   = val_q;
    last_d  = last_q;
    wr_en   = 1'b0;
    ov_d    = ov_q && !out_o.ready;
    om_d    = om_q;
    oval_d  = oval_q;
    ocnt_d  = ocnt_q;
    oeor_d  = oeor_q;
    oovf_d  = oovf_q;
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          if (pop_item_i.cmd == CmdLoad) begin
            if (len_q < DepthLen) begin
              wr_en = 1'b1;
              len_d = len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            val_d   = pop_item_i.value;
            last_d  = pop_item_i.last;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (in_range && lower) begin
          ptr_d = ptr_q + 1'b1;
        end else if (out_free) begin
          ov_d    = 1'b1;
          om_d    = hit;
          oval_d  = hit ? val_q : '0;
          ocnt_d  = cnt_next;
          oeor_d  = last_q;
          oovf_d  = ovf_q;
          ptr_d   = hit ? ptr_q + 1'b1 : ptr_q;
          cnt_d   = cnt_next;
          state_d = StIdle;
          if (last_q) begin
            len_d = '0;
            ptr_d = '0;
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q   <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
    om_q   <= om_d;
    oval_q <= oval_d;
    ocnt_q <= ocnt_d;
    oeor_q <= oeor_d;
    oovf_q <= oovf_d;
  end

  // store: one write, one registered read that follows the next pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[IdxW-1:0]] <= pop_item_i.value;
    end
    rdata_q <= mem_q[ptr_d[IdxW-1:0]];
  end

  assign out_o.valid       = ov_q;
  assign out_o.matched     = om_q;
  assign out_o.match_value = oval_q;
  assign out_o.match_count = ocnt_q;
  assign out_o.end_of_run  = oeor_q;
  assign out_o.overflow    = oovf_q;

endmodule

// ----- hw/rtl/sorted_set_intersection_core.sv -----
// Channel  Dir  Beat carries                                     Result per beat
// in_i     in   operation, value, last                           none or one
// out_o    out  matched, match_value, match_count, end_of_run,   one per probe
//               overflow
// Load beat: written while the back end stays idle. Probe: skips stored entries below
// the value through the single read port of the list store (one entry per cycle).
// Reset clears length, pointer, count and overflow; store contents stay unknown
// and entries at or above the length are never used, so no clearing pass.
// A 2-entry queue takes input beats while the back end scans or the result
// register waits on out_o.ready.
module sorted_set_intersection_core import ssi_pkg::*; #(
  parameter int unsigned ListDepth = ListDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssi_in_if.sink    in_i,
  ssi_out_if.source out_o
);

  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  ssi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  ssi_back #(
    .ListDepth (ListDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

// ----- hw/rtl/ssi_checker.sv -----
`include "sorted_set_intersection_core_assert.svh"

module ssi_checker import ssi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_matched_i,
  input logic [ValueW-1:0] out_match_value_i,
  input logic [CountW-1:0] out_match_count_i,
  input logic              out_end_of_run_i,
  input logic              out_overflow_i
);

  logic              acc;
  logic              prev_eor_q;
  logic              prev_ovf_q;
  logic [CountW-1:0] prev_cnt_q;

  assign acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_eor_q <= 1'b1;
      prev_ovf_q <= 1'b0;
      prev_cnt_q <= '0;
    end else if (acc) begin
      prev_eor_q <= out_end_of_run_i;
      prev_ovf_q <= out_overflow_i;
      prev_cnt_q <= out_match_count_i;
    end
  end

  `SSI_ASSERT(out_hold_a, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `SSI_ASSERT_IMPL(miss_zero_a, out_valid_i && !out_matched_i, out_match_value_i == '0, "miss value")
  `SSI_ASSERT_IMPL(first_cnt_a, acc && prev_eor_q, out_match_count_i == CountW'(out_matched_i), "run count")
  `SSI_ASSERT_IMPL(step_cnt_a, acc && !prev_eor_q, (out_match_count_i == prev_cnt_q + CountW'(out_matched_i)) || (prev_cnt_q == CountMax), "count step")
  `SSI_ASSERT_IMPL(ovf_keep_a, acc && !prev_eor_q && prev_ovf_q, out_overflow_i, "overflow lost")

endmodule

bind sorted_set_intersection_core ssi_checker u_ssi_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_matched_i     (out_o.matched),
  .out_match_value_i (out_o.match_value),
  .out_match_count_i (out_o.match_count),
  .out_end_of_run_i  (out_o.end_of_run),
  .out_overflow_i    (out_o.overflow)
);
